[hw/rtl/token_lexer_assert.svh]
// ----------------------------------------------------------------------------
// token lexer assertion macros
// shared property shorthands for the lexer modules
// ----------------------------------------------------------------------------
`ifndef TOKEN_LEXER_ASSERT_SVH
`define TOKEN_LEXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLEX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token lexer check failed");

// next-cycle implication, disabled during reset
`define TLEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token lexer check failed");

`endif

[hw/rtl/tlex_pkg.sv]
// ----------------------------------------------------------------------------
// tlex_pkg
// shared types, codes and character classes of the token lexer
// ----------------------------------------------------------------------------
`default_nettype none

package tlex_pkg;

  // default position counter width
  localparam int POS_WIDTH_DEF = 16;

  // result queue depth (two tokens per character at most)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // scan modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_Q1    = 3'd2;
  localparam logic [2:0] MODE_QX    = 3'd3;
  localparam logic [2:0] MODE_QH1   = 3'd4;
  localparam logic [2:0] MODE_QH2   = 3'd5;
  localparam logic [2:0] MODE_QC    = 3'd6;
  localparam logic [2:0] MODE_DONE  = 3'd7;

  // token codes
  localparam logic [6:0] CODE_END   = 7'd0;
  localparam logic [6:0] CODE_ERR   = 7'd1;
  localparam logic [6:0] CODE_CHR   = 7'd2;
  localparam logic [6:0] CODE_IDENT = 7'd3;

  // characters with a special role
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // one result token
  typedef struct packed {
    logic [6:0]  code;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tlex_tok_t;

  // tokens produced by one character
  typedef struct packed {
    logic [1:0] num;
    tlex_tok_t  tok0;
    tlex_tok_t  tok1;
  } tlex_step_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h7B || c == 8'h7D ||
           c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h2C ||
           c == 8'h24;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/token_lexer.sv]
// ----------------------------------------------------------------------------
// token_lexer
// streaming tokenizer, one source character per transfer
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one character (in_char_in) per
// transfer; zero marks the end of the text. Output channel out_valid/
// out_ready carries tokens: code, start position, length and a flag on the
// last token caused by a character. A character gives zero, one or two
// tokens.
// An accepted character waits in an input register until the queue has
// room for two tokens; the scan logic then writes its tokens into a
// four-entry result queue, whose head is offered on the output channel.
// Throughput is one character per cycle while the queue drains one token
// per cycle; a character that ends an identifier and opens a punctuation,
// end or error token yields two tokens, and the single output port then
// sets the pace. The input register advances only while the queue has
// room for two. When the receiver stalls, tokens wait in the queue and
// the input channel stops once the queue lacks room for two tokens.
// Reset clears the scan state, the position counter and the queue. After
// an end or error token characters are still taken but produce nothing
// until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module token_lexer #(
  parameter int POS_WIDTH = tlex_pkg::POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_token_code,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_run
);

  logic                     in_vld_r;
  logic [7:0]               char_r;
  logic                     room2;
  logic                     go;
  tlex_pkg::tlex_step_out_t step_out;
  tlex_pkg::tlex_tok_t      head;

  // input register
  assign go       = in_vld_r && room2;
  assign in_ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char_in;
    end
  end

  // scan logic
  tlex_step #(
    .POS_WIDTH(POS_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .char_in  (char_r),
    .step_out (step_out)
  );

  // result queue
  tlex_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_out),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_code   = head.code;
  assign out_token_start  = head.start;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last;

endmodule

`default_nettype wire

[hw/rtl/tlex_step.sv]
// ----------------------------------------------------------------------------
// tlex_step
// scan state registers and the per-character token decision
// ----------------------------------------------------------------------------
`default_nettype none

`include "token_lexer_assert.svh"

module tlex_step #(
  parameter int POS_WIDTH = tlex_pkg::POS_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic [7:0]               char_in,
  output tlex_pkg::tlex_step_out_t      step_out
);

  localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

  logic [2:0]           mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] begin_r, begin_nxt;
  logic [15:0]          cnt_r, cnt_nxt;

  // saturate a position into the 16-bit start field
  function automatic logic [15:0] sat16(input logic [POS_WIDTH-1:0] p);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(p);
    return (ext > EXT_W'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  // saturating position increment
  function automatic logic [POS_WIDTH-1:0] pinc(input logic [POS_WIDTH-1:0] p);
    return (&p) ? p : p + POS_WIDTH'(1);
  endfunction

  // decision for a character that opens a new token
  logic             st_emit;
  tlex_pkg::tlex_tok_t st_tok;
  logic [2:0]       st_mode;
  logic             st_mark;
  logic             st_ident;

  always_comb begin
    st_emit       = 1'b0;
    st_mark       = 1'b0;
    st_ident      = 1'b0;
    st_mode       = tlex_pkg::MODE_IDLE;
    st_tok.code   = tlex_pkg::CODE_ERR;
    st_tok.start  = sat16(pos_r);
    st_tok.len    = 16'd1;
    st_tok.last   = 1'b0;
    if (tlex_pkg::is_space(char_in)) begin
      st_mode = tlex_pkg::MODE_IDLE;
    end else if (char_in == tlex_pkg::CH_NUL) begin
      st_emit     = 1'b1;
      st_tok.code = tlex_pkg::CODE_END;
      st_mode     = tlex_pkg::MODE_DONE;
    end else if (tlex_pkg::is_punct(char_in)) begin
      st_emit     = 1'b1;
      st_tok.code = char_in[6:0];
    end else if (char_in == tlex_pkg::CH_QUOTE) begin
      st_mark = 1'b1;
      st_mode = tlex_pkg::MODE_Q1;
    end else if (tlex_pkg::is_alpha(char_in) || char_in == tlex_pkg::CH_UNDER) begin
      st_mark  = 1'b1;
      st_ident = 1'b1;
      st_mode  = tlex_pkg::MODE_IDENT;
    end else begin
      st_emit     = 1'b1;
      st_tok.code = tlex_pkg::CODE_ERR;
      st_mode     = tlex_pkg::MODE_DONE;
    end
  end

  // quote error and immediate tokens
  tlex_pkg::tlex_tok_t qerr_tok, imm_tok;

  always_comb begin
    qerr_tok.code  = tlex_pkg::CODE_ERR;
    qerr_tok.start = sat16(begin_r);
    qerr_tok.len   = 16'd1;
    qerr_tok.last  = 1'b0;
    imm_tok.code   = tlex_pkg::CODE_CHR;
    imm_tok.start  = sat16(pinc(begin_r));
    imm_tok.len    = (mode_r == tlex_pkg::MODE_QH2) ? 16'd3 : 16'd1;
    imm_tok.last   = 1'b0;
  end

  // mode transition and token selection
  logic [1:0]          num;
  tlex_pkg::tlex_tok_t t0, t1;

  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pinc(pos_r);
    num       = 2'd0;
    t0        = st_tok;
    t1        = st_tok;
    case (mode_r)
      tlex_pkg::MODE_DONE: begin
        pos_nxt = pos_r;
      end
      tlex_pkg::MODE_IDLE: begin
        mode_nxt = st_mode;
        if (st_mark) begin
          begin_nxt = pos_r;
        end
        if (st_ident) begin
          cnt_nxt = 16'd1;
        end
        num = {1'b0, st_emit};
      end
      tlex_pkg::MODE_IDENT: begin
        if (tlex_pkg::is_ident_char(char_in)) begin
          if (cnt_r != 16'hFFFF) begin
            cnt_nxt = cnt_r + 16'd1;
          end
        end else begin
          t0.code  = tlex_pkg::CODE_IDENT;
          t0.start = sat16(begin_r);
          t0.len   = cnt_r;
          mode_nxt = st_mode;
          if (st_mark) begin
            begin_nxt = pos_r;
          end
          if (st_ident) begin
            cnt_nxt = 16'd1;
          end
          num = st_emit ? 2'd2 : 2'd1;
        end
      end
      tlex_pkg::MODE_Q1: begin
        if (char_in == tlex_pkg::CH_X) begin
          mode_nxt = tlex_pkg::MODE_QX;
        end else if (char_in >= tlex_pkg::CH_BANG && char_in <= tlex_pkg::CH_TILDE) begin
          mode_nxt = tlex_pkg::MODE_QC;
        end else begin
          t0       = qerr_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_DONE;
        end
      end
      tlex_pkg::MODE_QX: begin
        if (char_in == tlex_pkg::CH_QUOTE) begin
          t0       = imm_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_IDLE;
        end else if (tlex_pkg::is_hex(char_in)) begin
          mode_nxt = tlex_pkg::MODE_QH1;
        end else begin
          t0       = qerr_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_DONE;
        end
      end
      tlex_pkg::MODE_QH1: begin
        if (tlex_pkg::is_hex(char_in)) begin
          mode_nxt = tlex_pkg::MODE_QH2;
        end else begin
          t0       = qerr_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_DONE;
        end
      end
      tlex_pkg::MODE_QH2, tlex_pkg::MODE_QC: begin
        if (char_in == tlex_pkg::CH_QUOTE) begin
          t0       = imm_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_IDLE;
        end else begin
          t0       = qerr_tok;
          num      = 2'd1;
          mode_nxt = tlex_pkg::MODE_DONE;
        end
      end
      default: begin
        mode_nxt = tlex_pkg::MODE_DONE;
        pos_nxt  = pos_r;
      end
    endcase
  end

  // last-of-run flags
  always_comb begin
    step_out.num       = go ? num : 2'd0;
    step_out.tok0      = t0;
    step_out.tok1      = t1;
    step_out.tok0.last = (num == 2'd1);
    step_out.tok1.last = 1'b1;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tlex_pkg::MODE_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      cnt_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // checks
  `TLEX_ASSERT_NEXT(a_done_holds, clk, rst_n, mode_r == tlex_pkg::MODE_DONE,
    mode_r == tlex_pkg::MODE_DONE && $stable(pos_r))
  `TLEX_ASSERT_NOW(a_two_only_ident, clk, rst_n, step_out.num == 2'd2,
    mode_r == tlex_pkg::MODE_IDENT)
  `TLEX_ASSERT_NOW(a_final_token_ends, clk, rst_n,
    go && (st_emit && (mode_r == tlex_pkg::MODE_IDLE) && st_mode == tlex_pkg::MODE_DONE),
    step_out.num == 2'd1 && mode_nxt == tlex_pkg::MODE_DONE)

endmodule

`default_nettype wire

[hw/rtl/tlex_outq.sv]
// ----------------------------------------------------------------------------
// tlex_outq
// small result queue taking up to two tokens a cycle, giving one while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

`include "token_lexer_assert.svh"

module tlex_outq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tlex_pkg::tlex_step_out_t push,
  output logic                        room2,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tlex_pkg::tlex_tok_t         head
);

  tlex_pkg::tlex_tok_t mem_r [tlex_pkg::QUEUE_DEPTH];

  logic [tlex_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [tlex_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [tlex_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        pop;
  logic [tlex_pkg::QPTR_W-1:0] wp1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rp_r];
  assign room2     = (cnt_r <= tlex_pkg::QCNT_W'(tlex_pkg::QUEUE_DEPTH - 2));
  assign wp1       = wp_r + tlex_pkg::QPTR_W'(1);

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r + tlex_pkg::QPTR_W'(push.num);
    rp_nxt  = pop ? rp_r + tlex_pkg::QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + tlex_pkg::QCNT_W'(push.num) - tlex_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wp_r] <= push.tok0;
    end
    if (push.num == 2'd2) begin
      mem_r[wp1] <= push.tok1;
    end
  end

  // checks
  `TLEX_ASSERT_NOW(a_push_has_room, clk, rst_n, push.num != 2'd0, room2)
  `TLEX_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
    cnt_r <= tlex_pkg::QCNT_W'(tlex_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire
